### rtl/core/coo_pkg.sv
// Shared types and constants for the COO to CSR converter.
`timescale 1ns / 1ps

package coo_pkg;

	localparam int MAX_NODES = 1024;
	localparam int MAX_PAIRS = 1024;

	localparam int NODE_W  = 10;
	localparam int CNT_W   = 11;
	localparam int RP_W    = 12;
	localparam int RP_AW   = 11;
	localparam int COL_AW  = 11;
	localparam int IDX_W   = 12;
	localparam int DATA_W  = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// Item function codes.
	localparam logic [1:0] FUNC_LOAD    = 2'd0;
	localparam logic [1:0] FUNC_BUILD   = 2'd1;
	localparam logic [1:0] FUNC_RD_ROW  = 2'd2;
	localparam logic [1:0] FUNC_RD_COL  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_NODES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC = 2'd1;

	typedef struct packed {
		logic [1:0]        func;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic [IDX_W-1:0]  read_index;
	} item_word_t;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              error;
	} result_word_t;

endpackage

### rtl/core/coo_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module coo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/coo_to_csr_converter.sv
// Top level of the COO to CSR converter: control sequencer and its three memories.
`timescale 1ns / 1ps

//  channel   | direction | handshake                  | word
//  ----------+-----------+----------------------------+----------------------------------
//  item      | in        | item_valid / item_ready    | func, node_a, node_b, read_index
//  result    | out       | result_valid / result_ready| data, error
//  cfg       | in        | cfg_wr_en (no wait)        | cfg_index, cfg_data
//
//  A load needs no memory read; a row or column read makes one memory read. A build
//  clears the n rows, then runs a counting pair pass, a prefix pass, a filling pair
//  pass, a shift pass and a final step; an in-range pair updates its first endpoint
//  (both endpoints in symmetric mode), and an out-of-range pair is skipped.
//  Reset needs no clearing pass: row pointers are cleared by each build before use.
//  A new word is taken once the sequencer is idle and the result register is free.

module coo_to_csr_converter
	import coo_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_word_t            item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_word_t          result,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_RD_WAIT = 4'd1;
	localparam logic [3:0] S_CLR     = 4'd2;
	localparam logic [3:0] S_P_RD    = 4'd3;
	localparam logic [3:0] S_P_CHK   = 4'd4;
	localparam logic [3:0] S_A_WR    = 4'd5;
	localparam logic [3:0] S_B_RD    = 4'd6;
	localparam logic [3:0] S_B_WR    = 4'd7;
	localparam logic [3:0] S_PS_RD   = 4'd8;
	localparam logic [3:0] S_PS_WR   = 4'd9;
	localparam logic [3:0] S_SH_RD   = 4'd10;
	localparam logic [3:0] S_SH_WR   = 4'd11;
	localparam logic [3:0] S_FIN     = 4'd12;

	logic [3:0]            state_q;
	logic [CNT_W-1:0]      num_nodes_q;
	logic                  sym_q;
	logic [CNT_W-1:0]      pair_count_q;
	logic                  built_q;
	logic [RP_W-1:0]       total_q;
	logic [CNT_W-1:0]      built_rows_q;
	logic [CNT_W-1:0]      idx_q;
	logic                  pass_q;
	logic                  sel_col_q;
	logic [RP_W-1:0]       sum_q;
	logic [RP_W-1:0]       prev_q;
	logic                  result_valid_q;
	result_word_t          result_q;

	logic [CNT_W-1:0]      n_use;
	logic [CNT_W-1:0]      n_m1;
	logic [CNT_W-1:0]      idx_next;
	logic                  accept;
	logic                  load_err;
	logic                  row_err;
	logic                  col_err;
	logic                  pair_done;
	logic                  in_range;
	logic                  res_load;
	logic                  cfg_clr;

	logic                  rp_we;
	logic [RP_AW-1:0]      rp_waddr;
	logic [RP_W-1:0]       rp_wdata;
	logic [RP_AW-1:0]      rp_raddr;
	logic [RP_W-1:0]       rp_rd;
	logic                  pair_we;
	logic [2*NODE_W-1:0]   pair_rd;
	logic [NODE_W-1:0]     pa;
	logic [NODE_W-1:0]     pb;
	logic                  col_we;
	logic [COL_AW-1:0]     col_waddr;
	logic [NODE_W-1:0]     col_wdata;
	logic [NODE_W-1:0]     col_rd;

	// Rows in use, clamped to 1..MAX_NODES.
	always_comb begin
		if (num_nodes_q == '0) begin
			n_use = CNT_W'(1);
		end else if (num_nodes_q > CNT_W'(MAX_NODES)) begin
			n_use = CNT_W'(MAX_NODES);
		end else begin
			n_use = num_nodes_q;
		end
	end

	assign n_m1      = n_use - CNT_W'(1);
	assign idx_next  = idx_q + CNT_W'(1);
	assign pair_done = (idx_next == pair_count_q);
	assign pa        = pair_rd[2*NODE_W-1:NODE_W];
	assign pb        = pair_rd[NODE_W-1:0];
	assign in_range  = ({1'b0, pa} < n_use) && ({1'b0, pb} < n_use);

	assign item_ready   = (state_q == S_IDLE) && (!result_valid_q || result_ready);
	assign accept       = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Refusal checks for the incoming word.
	assign load_err = ({1'b0, item.node_a} >= n_use) || ({1'b0, item.node_b} >= n_use)
		|| (pair_count_q == CNT_W'(MAX_PAIRS));
	assign row_err  = !built_q || (item.read_index > {1'b0, built_rows_q});
	assign col_err  = !built_q || (item.read_index >= total_q);

	// The result register is loaded by loads, refused reads, read completion and build end.
	assign res_load = (accept && ((item.func == FUNC_LOAD)
		|| ((item.func == FUNC_RD_ROW) && row_err)
		|| ((item.func == FUNC_RD_COL) && col_err)))
		|| (state_q == S_RD_WAIT) || (state_q == S_FIN);

	// A write to the node count or symmetric register invalidates the built structure.
	assign cfg_clr = cfg_wr_en && ((cfg_index == CFG_NUM_NODES) || (cfg_index == CFG_SYMMETRIC));

	// Pair buffer: written by loads, read by the two pair passes.
	assign pair_we = accept && (item.func == FUNC_LOAD) && !load_err;

	coo_ram #(.WIDTH(2 * NODE_W), .DEPTH(MAX_PAIRS)) u_pair_ram (
		.clk   (clk),
		.we    (pair_we),
		.waddr (pair_count_q[NODE_W-1:0]),
		.wdata ({item.node_a, item.node_b}),
		.raddr (idx_q[NODE_W-1:0]),
		.rdata (pair_rd)
	);

	// Memory port selection per sequencer state.
	always_comb begin
		rp_we     = 1'b0;
		rp_waddr  = idx_q;
		rp_wdata  = '0;
		rp_raddr  = idx_q;
		col_we    = 1'b0;
		col_waddr = rp_rd[COL_AW-1:0];
		col_wdata = pb;
		unique case (state_q)
			S_IDLE: begin
				rp_raddr = item.read_index[RP_AW-1:0];
			end
			S_CLR: begin
				rp_we = 1'b1;
			end
			S_P_CHK: begin
				rp_raddr = {1'b0, pa};
			end
			S_A_WR: begin
				rp_we     = 1'b1;
				rp_waddr  = {1'b0, pa};
				rp_wdata  = rp_rd + RP_W'(1);
				col_we    = pass_q;
				col_wdata = pb;
			end
			S_B_RD: begin
				rp_raddr = {1'b0, pb};
			end
			S_B_WR: begin
				rp_we     = 1'b1;
				rp_waddr  = {1'b0, pb};
				rp_wdata  = rp_rd + RP_W'(1);
				col_we    = pass_q;
				col_wdata = pa;
			end
			S_PS_WR: begin
				rp_we    = 1'b1;
				rp_wdata = sum_q;
			end
			S_SH_WR: begin
				rp_we    = 1'b1;
				rp_wdata = prev_q;
			end
			S_FIN: begin
				rp_we    = 1'b1;
				rp_waddr = n_use;
				rp_wdata = sum_q;
			end
			default: begin
			end
		endcase
	end

	coo_ram #(.WIDTH(RP_W), .DEPTH(MAX_NODES + 1)) u_rp_ram (
		.clk   (clk),
		.we    (rp_we),
		.waddr (rp_waddr),
		.wdata (rp_wdata),
		.raddr (rp_raddr),
		.rdata (rp_rd)
	);

	coo_ram #(.WIDTH(NODE_W), .DEPTH(2 * MAX_PAIRS)) u_col_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr (col_waddr),
		.wdata (col_wdata),
		.raddr (item.read_index[COL_AW-1:0]),
		.rdata (col_rd)
	);

	// Sequencer, configuration registers and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			num_nodes_q    <= CNT_W'(MAX_NODES);
			sym_q          <= 1'b1;
			pair_count_q   <= '0;
			built_q        <= 1'b0;
			total_q        <= '0;
			built_rows_q   <= '0;
			idx_q          <= '0;
			pass_q         <= 1'b0;
			sel_col_q      <= 1'b0;
			sum_q          <= '0;
			prev_q         <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_clr || pair_we) begin
				built_q <= 1'b0;
			end else if (state_q == S_FIN) begin
				built_q <= 1'b1;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_NUM_NODES: begin
						num_nodes_q <= cfg_data;
					end
					CFG_SYMMETRIC: begin
						sym_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			unique case (state_q) inside
				S_IDLE: begin
					if (accept) begin
						unique case (item.func)
							FUNC_LOAD: begin
								if (load_err) begin
									result_q <= '{data: '0, error: 1'b1};
								end else begin
									result_q <= '{data: DATA_W'(pair_count_q) + DATA_W'(1),
										error: 1'b0};
									pair_count_q <= pair_count_q + CNT_W'(1);
								end
							end
							FUNC_BUILD: begin
								idx_q   <= '0;
								state_q <= S_CLR;
							end
							FUNC_RD_ROW: begin
								if (row_err) begin
									result_q <= '{data: '0, error: 1'b1};
								end else begin
									sel_col_q <= 1'b0;
									state_q   <= S_RD_WAIT;
								end
							end
							FUNC_RD_COL: begin
								if (col_err) begin
									result_q <= '{data: '0, error: 1'b1};
								end else begin
									sel_col_q <= 1'b1;
									state_q   <= S_RD_WAIT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RD_WAIT: begin
					result_q <= '{data: sel_col_q ? DATA_W'(col_rd) : rp_rd, error: 1'b0};
					state_q  <= S_IDLE;
				end
				S_CLR: begin
					sum_q <= '0;
					if (idx_q == n_m1) begin
						idx_q   <= '0;
						pass_q  <= 1'b0;
						state_q <= (pair_count_q == '0) ? S_PS_RD : S_P_RD;
					end else begin
						idx_q <= idx_next;
					end
				end
				S_P_RD: begin
					state_q <= S_P_CHK;
				end
				S_P_CHK, S_A_WR, S_B_WR: begin
					if (state_q == S_P_CHK && in_range) begin
						state_q <= S_A_WR;
					end else if (state_q == S_A_WR && sym_q) begin
						state_q <= S_B_RD;
					end else if (pair_done) begin
						idx_q   <= '0;
						state_q <= pass_q ? S_SH_RD : S_PS_RD;
					end else begin
						idx_q   <= idx_next;
						state_q <= S_P_RD;
					end
				end
				S_B_RD: begin
					state_q <= S_B_WR;
				end
				S_PS_RD: begin
					state_q <= S_PS_WR;
				end
				S_PS_WR: begin
					sum_q <= sum_q + rp_rd;
					if (idx_q == n_m1) begin
						idx_q   <= '0;
						pass_q  <= 1'b1;
						prev_q  <= '0;
						state_q <= (pair_count_q == '0) ? S_SH_RD : S_P_RD;
					end else begin
						idx_q   <= idx_next;
						state_q <= S_PS_RD;
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					prev_q <= rp_rd;
					if (idx_q == n_m1) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_next;
						state_q <= S_SH_RD;
					end
				end
				S_FIN: begin
					total_q      <= sum_q;
					built_rows_q <= n_use;
					result_q     <= '{data: sum_q, error: 1'b0};
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A refused word never carries data.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.error |-> result.data == '0)
		else $error("error result carries nonzero data");

	// The pair count never passes the buffer size.
	assert property (@(posedge clk) disable iff (!arst_n)
		pair_count_q <= CNT_W'(MAX_PAIRS))
		else $error("pair count beyond capacity");

	// A finished build leaves the built flag set and a result pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> built_q && result_valid_q)
		else $error("build finished without result");

	// The built total fits the column store.
	assert property (@(posedge clk) disable iff (!arst_n)
		built_q |-> total_q <= RP_W'(2 * MAX_PAIRS))
		else $error("built total beyond column store");

endmodule
